// ===== rtl/sfe_pkg.sv =====
// Shared types and constants of the serial frame encoder.
package sfe_pkg;

	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_ADDR0 = 8'h61;
	localparam logic [7:0] CH_BASE  = 8'h3D;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int SUM_W     = 12;
	localparam int STEP_W    = 3;
	localparam int JQ_DEPTH  = 4;
	localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);

	localparam logic [1:0] POS_ZERO = 2'd0;
	localparam logic [1:0] POS_ONE  = 2'd1;
	localparam logic [1:0] POS_TWO  = 2'd2;

	localparam logic FUNC_START   = 1'b0;
	localparam logic FUNC_PAYLOAD = 1'b1;

	typedef enum logic {
		JOB_HDR = 1'b0,
		JOB_GRP = 1'b1
	} job_op_t;

	typedef struct packed {
		job_op_t    op;
		logic [7:0] d0;
		logic [7:0] d1;
		logic [7:0] d2;
		logic       close;
	} job_t;

	// Printable form of a 6-bit slice.
	function automatic logic [7:0] six_char(input logic [5:0] v);
		six_char = CH_BASE + {2'b00, v};
	endfunction

endpackage

// ===== rtl/serial_frame_encoder_sum_check.sv =====
// Top level of the serial text frame encoder with additive check.
// A result passes through the job queue, the current-job register and the output register.
// Throughput: one item per cycle in while the job queue has room; one character per cycle
// out while pop is held, and a steady payload stream gives 4 characters per 3 bytes.
// The character emitter sets the output rate; a 4-entry job queue absorbs bursts.
// Reset (arst_n low) closes any open frame and empties the queue and output.
module serial_frame_encoder_sum_check (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic [7:0] command,
	input  logic [7:0] dest_addr,
	input  logic [7:0] payload,
	input  logic       final_byte,
	input  logic       empty_frame,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] tx_char,
	output logic       frame_end,
	output logic       run_last
);

	logic          accept;
	logic          job_push;
	sfe_pkg::job_t job_in;
	sfe_pkg::job_t job_head;
	logic          job_pop;
	logic          q_full;
	logic          q_empty;

	// Take an item whenever the job queue has room; every item makes at most one job.
	assign full   = q_full;
	assign accept = push && !q_full;

	// Classify the item, hold partial groups, and build jobs.
	sfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.func        (func),
		.command     (command),
		.dest_addr   (dest_addr),
		.payload     (payload),
		.final_byte  (final_byte),
		.empty_frame (empty_frame),
		.job_push    (job_push),
		.job         (job_in)
	);

	// Decouple the front from the emitter so either side can stall.
	sfe_job_q u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_job  (job_in),
		.rd_en   (job_pop),
		.rd_job  (job_head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// Emit one character per transfer, advancing the running sum.
	sfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_job     (job_head),
		.q_pop     (job_pop),
		.pop       (pop),
		.empty     (empty),
		.tx_char   (tx_char),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule

// ===== rtl/sfe_front.sv =====
// Front end: accept items, track the open frame and pack payload into jobs.
module sfe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              func,
	input  logic [7:0]        command,
	input  logic [7:0]        dest_addr,
	input  logic [7:0]        payload,
	input  logic              final_byte,
	input  logic              empty_frame,
	output logic              job_push,
	output sfe_pkg::job_t     job
);

	logic       frame_open_q;
	logic [1:0] group_pos_q;
	logic [7:0] held_first_q;
	logic [7:0] held_second_q;

	always_comb begin
		job_push  = 1'b0;
		job.op    = sfe_pkg::JOB_HDR;
		job.d0    = dest_addr;
		job.d1    = command;
		job.d2    = 8'd0;
		job.close = empty_frame;
		if (func == sfe_pkg::FUNC_START) begin
			job_push = accept;
		end else begin
			job.op    = sfe_pkg::JOB_GRP;
			job.close = final_byte;
			case (group_pos_q)
				sfe_pkg::POS_ZERO: begin
					job.d0   = payload;
					job.d1   = 8'd0;
					job_push = accept && frame_open_q && final_byte;
				end
				sfe_pkg::POS_ONE: begin
					job.d0   = held_first_q;
					job.d1   = payload;
					job_push = accept && frame_open_q && final_byte;
				end
				default: begin
					job.d0   = held_first_q;
					job.d1   = held_second_q;
					job.d2   = payload;
					job_push = accept && frame_open_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			group_pos_q  <= sfe_pkg::POS_ZERO;
		end else if (accept) begin
			if (func == sfe_pkg::FUNC_START) begin
				frame_open_q <= !empty_frame;
				group_pos_q  <= sfe_pkg::POS_ZERO;
			end else if (frame_open_q) begin
				if (final_byte) begin
					frame_open_q <= 1'b0;
					group_pos_q  <= sfe_pkg::POS_ZERO;
				end else begin
					case (group_pos_q)
						sfe_pkg::POS_ZERO: group_pos_q <= sfe_pkg::POS_ONE;
						sfe_pkg::POS_ONE:  group_pos_q <= sfe_pkg::POS_TWO;
						default:           group_pos_q <= sfe_pkg::POS_ZERO;
					endcase
				end
			end
		end
	end

	// Hold bytes of a partial group.
	always_ff @(posedge clk) begin
		if (accept && func == sfe_pkg::FUNC_PAYLOAD && frame_open_q && !final_byte) begin
			if (group_pos_q == sfe_pkg::POS_ZERO) begin
				held_first_q <= payload;
			end
			if (group_pos_q == sfe_pkg::POS_ONE) begin
				held_second_q <= payload;
			end
		end
	end

endmodule

// ===== rtl/sfe_job_q.sv =====
// Short job queue between the front end and the character emitter.
module sfe_job_q (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  sfe_pkg::job_t     wr_job,
	input  logic              rd_en,
	output sfe_pkg::job_t     rd_job,
	output logic              q_full,
	output logic              q_empty
);

	sfe_pkg::job_t                  mem_q [sfe_pkg::JQ_DEPTH];
	logic [sfe_pkg::JQ_PTR_W-1:0]   wr_ptr_q;
	logic [sfe_pkg::JQ_PTR_W-1:0]   rd_ptr_q;
	logic [sfe_pkg::JQ_PTR_W:0]     count_q;

	assign rd_job  = mem_q[rd_ptr_q];
	assign q_full  = (count_q == (sfe_pkg::JQ_PTR_W+1)'(sfe_pkg::JQ_DEPTH));
	assign q_empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/sfe_back.sv =====
// Back end: expand jobs into characters, keep the frame sum, hold the output.
module sfe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  sfe_pkg::job_t     q_job,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        tx_char,
	output logic              frame_end,
	output logic              run_last
);

	sfe_pkg::job_t                 cur_q;
	logic                          cur_valid_q;
	logic [sfe_pkg::STEP_W-1:0]    step_q;
	logic [sfe_pkg::SUM_W-1:0]     sum_q;
	logic [5:0]                    sum_lo_q;
	logic                          out_valid_q;
	logic [7:0]                    tx_char_q;
	logic                          frame_end_q;
	logic                          run_last_q;

	logic                          adv;
	logic                          is_last;
	logic [sfe_pkg::STEP_W-1:0]    last_step;
	logic [sfe_pkg::STEP_W-1:0]    close_base;
	logic [sfe_pkg::STEP_W-1:0]    cstep;
	logic                          in_close;
	logic [7:0]                    ch;
	logic                          ch_end;
	logic [sfe_pkg::SUM_W-1:0]     sum_base;

	assign adv = cur_valid_q && (!out_valid_q || pop);

	always_comb begin
		if (cur_q.op == sfe_pkg::JOB_HDR) begin
			close_base = sfe_pkg::STEP_W'(3);
		end else begin
			close_base = sfe_pkg::STEP_W'(4);
		end
		last_step = cur_q.close ? (close_base + sfe_pkg::STEP_W'(2))
			: (close_base - sfe_pkg::STEP_W'(1));
		is_last  = (step_q == last_step);
		in_close = (step_q >= close_base);
		cstep    = step_q - close_base;
	end

	// Pick the character for the current step.
	always_comb begin
		ch     = sfe_pkg::CH_CR;
		ch_end = 1'b0;
		if (in_close) begin
			case (cstep)
				sfe_pkg::STEP_W'(0): ch = sfe_pkg::six_char(sum_q[11:6]);
				sfe_pkg::STEP_W'(1): ch = sfe_pkg::six_char(sum_lo_q);
				default: begin
					ch     = sfe_pkg::CH_CR;
					ch_end = 1'b1;
				end
			endcase
		end else if (cur_q.op == sfe_pkg::JOB_HDR) begin
			case (step_q)
				sfe_pkg::STEP_W'(0): ch = sfe_pkg::CH_START;
				sfe_pkg::STEP_W'(1): ch = sfe_pkg::CH_ADDR0 + cur_q.d0;
				default:             ch = cur_q.d1;
			endcase
		end else begin
			case (step_q)
				sfe_pkg::STEP_W'(0): ch = sfe_pkg::six_char(cur_q.d0[7:2]);
				sfe_pkg::STEP_W'(1): ch = sfe_pkg::six_char({cur_q.d0[1:0], cur_q.d1[7:4]});
				sfe_pkg::STEP_W'(2): ch = sfe_pkg::six_char({cur_q.d1[3:0], cur_q.d2[7:6]});
				default:             ch = sfe_pkg::six_char(cur_q.d2[5:0]);
			endcase
		end
		if (cur_q.op == sfe_pkg::JOB_HDR && step_q == '0) begin
			sum_base = '0;
		end else begin
			sum_base = sum_q;
		end
	end

	assign q_pop = !q_empty && (!cur_valid_q || (adv && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (adv) begin
				cur_valid_q <= !is_last;
				step_q      <= step_q + 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_job;
		end
		if (adv) begin
			sum_q       <= sum_base + {{(sfe_pkg::SUM_W-8){1'b0}}, ch};
			tx_char_q   <= ch;
			frame_end_q <= ch_end;
			run_last_q  <= is_last;
			if (in_close && cstep == '0) begin
				sum_lo_q <= sum_q[5:0];
			end
		end
	end

	assign empty     = !out_valid_q;
	assign tx_char   = tx_char_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule
